FILE: rtl/core/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation block.
`default_nettype none

package qvr_pkg;

   // Fraction bits of the Q2.14 operands and of the rounding steps.
   localparam int FRAC_BITS = 14;

   // Operand and intermediate widths.
   localparam int VEC_W    = 16;
   localparam int P_W      = FRAC_BITS + 6;
   localparam int PA_W     = 2 * VEC_W;
   localparam int SA_W     = PA_W + 2;
   localparam int PB_W     = VEC_W + P_W;
   localparam int SB_W     = PB_W + 2;
   localparam int NUM_PROD = 12;
   localparam int NUM_COMP = 3;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [P_W-1:0]   p_type;
   typedef logic signed [PA_W-1:0]  prod_a_type;
   typedef logic signed [SA_W-1:0]  sum_a_type;
   typedef logic signed [PB_W-1:0]  prod_b_type;
   typedef logic signed [SB_W-1:0]  sum_b_type;

   typedef struct packed {
      vec_type w;
      vec_type x;
      vec_type y;
      vec_type z;
   } quat_type;

   // Half an LSB of the result, added before the arithmetic shift.
   localparam sum_a_type ROUND_A = sum_a_type'(1) <<< (FRAC_BITS - 1);
   localparam sum_b_type ROUND_B = sum_b_type'(1) <<< (FRAC_BITS - 1);

   // Saturation limits of an output component.
   localparam vec_type VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
   localparam vec_type VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/core/qvr_if.sv
// Request and response channel interfaces of the quaternion vector rotation block.
`default_nettype none

interface qvr_req_if
   import qvr_pkg::*;
   ();
   logic    valid;
   logic    ready;
   vec_type quat_w;
   vec_type quat_x;
   vec_type quat_y;
   vec_type quat_z;
   vec_type vec_x;
   vec_type vec_y;
   vec_type vec_z;

   modport source (
      output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
      input  ready
   );
   modport sink (
      input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
      output ready
   );
endinterface

interface qvr_rsp_if
   import qvr_pkg::*;
   ();
   logic    valid;
   logic    ready;
   vec_type rot_x;
   vec_type rot_y;
   vec_type rot_z;
   logic    clipped;

   modport source (
      output valid, rot_x, rot_y, rot_z, clipped,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, clipped,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/quaternion_vector_rotation.sv
// Top level: rotates a 3-vector by a quaternion as q * v * conj(q) in fixed point.
//
// The request channel (req_chan) carries a quaternion (w,x,y,z) and a vector,
// all signed Q2.14. The response channel (rsp_chan) returns the rotated vector,
// saturated to Q2.14, and a clipped flag set when any component saturated.
// Every request gives exactly one response, in order.
// The datapath is a four-stage pipeline: products of v * conj(q), their sums
// rounded to the intermediate P, products of q * P, then the rounded and
// saturated sums in the output register. A request taken into the stage 1
// register passes the stage 2 and 3 registers before its response shows valid.
// Throughput is one request per cycle while rsp_chan.ready is high; each stage
// holds one multiplier level or one adder tree, so nothing limits it below that.
// Each stage takes new data whenever it is empty or the stage after it moves,
// so bubbles close up. When the receiver holds rsp_chan.ready low the response
// stays valid and unchanged, the pipeline fills, and req_chan.ready drops only
// once all four stages hold requests.
// Synchronous reset empties the pipeline; no response is valid after it.
`default_nettype none

module quaternion_vector_rotation
   import qvr_pkg::*;
   (
      input  wire logic  clock,
      input  wire logic  reset,
      qvr_req_if.sink    req_chan,
      qvr_rsp_if.source  rsp_chan
   );

   // Stage registers.
   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   prod_a_type prod_a_ff [NUM_PROD];
   prod_a_type prod_a_in [NUM_PROD];
   quat_type   q1_ff, q1_in;
   quat_type   q2_ff;
   p_type      p_ff [4];
   p_type      p_in [4];
   prod_b_type prod_b_ff [NUM_PROD];
   prod_b_type prod_b_in [NUM_PROD];
   vec_type    rot_ff [NUM_COMP];
   vec_type    rot_in [NUM_COMP];
   logic       clipped_ff, clipped_in;

   logic       s1_ready, s2_ready, s3_ready, s4_ready;
   sum_a_type  sum_a [4];
   sum_b_type  sum_b [NUM_COMP];
   sum_b_type  shift_b [NUM_COMP];
   logic [NUM_COMP-1:0] sat;

   // Each stage moves when it is empty or its successor moves.
   assign s4_ready       = !s4_valid_ff || rsp_chan.ready;
   assign s3_ready       = !s3_valid_ff || s4_ready;
   assign s2_ready       = !s2_valid_ff || s3_ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_chan.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: the twelve products of v * conj(q).
   always_comb begin
      q1_in.w       = req_chan.quat_w;
      q1_in.x       = req_chan.quat_x;
      q1_in.y       = req_chan.quat_y;
      q1_in.z       = req_chan.quat_z;
      prod_a_in[0]  = PA_W'(req_chan.vec_x) * PA_W'(req_chan.quat_x);
      prod_a_in[1]  = PA_W'(req_chan.vec_y) * PA_W'(req_chan.quat_y);
      prod_a_in[2]  = PA_W'(req_chan.vec_z) * PA_W'(req_chan.quat_z);
      prod_a_in[3]  = PA_W'(req_chan.vec_x) * PA_W'(req_chan.quat_w);
      prod_a_in[4]  = PA_W'(req_chan.vec_y) * PA_W'(req_chan.quat_z);
      prod_a_in[5]  = PA_W'(req_chan.vec_z) * PA_W'(req_chan.quat_y);
      prod_a_in[6]  = PA_W'(req_chan.vec_x) * PA_W'(req_chan.quat_z);
      prod_a_in[7]  = PA_W'(req_chan.vec_y) * PA_W'(req_chan.quat_w);
      prod_a_in[8]  = PA_W'(req_chan.vec_z) * PA_W'(req_chan.quat_x);
      prod_a_in[9]  = PA_W'(req_chan.vec_x) * PA_W'(req_chan.quat_y);
      prod_a_in[10] = PA_W'(req_chan.vec_y) * PA_W'(req_chan.quat_x);
      prod_a_in[11] = PA_W'(req_chan.vec_z) * PA_W'(req_chan.quat_w);
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         q1_ff <= q1_in;
         for (int i = 0; i < NUM_PROD; i++) begin
            prod_a_ff[i] <= prod_a_in[i];
         end
      end
   end

   // Stage 2: sum, round and wrap the four components of P.
   always_comb begin
      sum_a[0] = SA_W'(prod_a_ff[0]) + SA_W'(prod_a_ff[1]) + SA_W'(prod_a_ff[2]) + ROUND_A;
      sum_a[1] = SA_W'(prod_a_ff[3]) - SA_W'(prod_a_ff[4]) + SA_W'(prod_a_ff[5]) + ROUND_A;
      sum_a[2] = SA_W'(prod_a_ff[6]) + SA_W'(prod_a_ff[7]) - SA_W'(prod_a_ff[8]) + ROUND_A;
      sum_a[3] = SA_W'(prod_a_ff[10]) - SA_W'(prod_a_ff[9]) + SA_W'(prod_a_ff[11])
                 + ROUND_A;
      for (int i = 0; i < 4; i++) begin
         p_in[i] = P_W'(sum_a[i] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         q2_ff <= q1_ff;
         for (int i = 0; i < 4; i++) begin
            p_ff[i] <= p_in[i];
         end
      end
   end

   // Stage 3: the twelve products of q * P that feed the vector part.
   always_comb begin
      prod_b_in[0]  = PB_W'(q2_ff.w) * PB_W'(p_ff[1]);
      prod_b_in[1]  = PB_W'(q2_ff.x) * PB_W'(p_ff[0]);
      prod_b_in[2]  = PB_W'(q2_ff.y) * PB_W'(p_ff[3]);
      prod_b_in[3]  = PB_W'(q2_ff.z) * PB_W'(p_ff[2]);
      prod_b_in[4]  = PB_W'(q2_ff.w) * PB_W'(p_ff[2]);
      prod_b_in[5]  = PB_W'(q2_ff.x) * PB_W'(p_ff[3]);
      prod_b_in[6]  = PB_W'(q2_ff.y) * PB_W'(p_ff[0]);
      prod_b_in[7]  = PB_W'(q2_ff.z) * PB_W'(p_ff[1]);
      prod_b_in[8]  = PB_W'(q2_ff.w) * PB_W'(p_ff[3]);
      prod_b_in[9]  = PB_W'(q2_ff.x) * PB_W'(p_ff[2]);
      prod_b_in[10] = PB_W'(q2_ff.y) * PB_W'(p_ff[1]);
      prod_b_in[11] = PB_W'(q2_ff.z) * PB_W'(p_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         for (int i = 0; i < NUM_PROD; i++) begin
            prod_b_ff[i] <= prod_b_in[i];
         end
      end
   end

   // Stage 4: sum, round and saturate each vector component.
   always_comb begin
      sum_b[0] = SB_W'(prod_b_ff[0]) + SB_W'(prod_b_ff[1]) + SB_W'(prod_b_ff[2])
                 - SB_W'(prod_b_ff[3]) + ROUND_B;
      sum_b[1] = SB_W'(prod_b_ff[4]) - SB_W'(prod_b_ff[5]) + SB_W'(prod_b_ff[6])
                 + SB_W'(prod_b_ff[7]) + ROUND_B;
      sum_b[2] = SB_W'(prod_b_ff[8]) + SB_W'(prod_b_ff[9]) - SB_W'(prod_b_ff[10])
                 + SB_W'(prod_b_ff[11]) + ROUND_B;
      for (int i = 0; i < NUM_COMP; i++) begin
         shift_b[i] = sum_b[i] >>> FRAC_BITS;
         // The value fits when all bits from the output sign bit upward agree.
         sat[i] = !((&shift_b[i][SB_W-1:VEC_W-1]) || !(|shift_b[i][SB_W-1:VEC_W-1]));
         if (!sat[i]) begin
            rot_in[i] = shift_b[i][VEC_W-1:0];
         end else if (shift_b[i][SB_W-1]) begin
            rot_in[i] = VEC_MIN;
         end else begin
            rot_in[i] = VEC_MAX;
         end
      end
      clipped_in = |sat;
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         clipped_ff <= clipped_in;
         for (int i = 0; i < NUM_COMP; i++) begin
            rot_ff[i] <= rot_in[i];
         end
      end
   end

   // Response channel driven straight from the output register.
   assign rsp_chan.valid   = s4_valid_ff;
   assign rsp_chan.rot_x   = rot_ff[0];
   assign rsp_chan.rot_y   = rot_ff[1];
   assign rsp_chan.rot_z   = rot_ff[2];
   assign rsp_chan.clipped = clipped_ff;

endmodule

`default_nettype wire

FILE: rtl/core/qvr_checker.sv
// Port-level assertions for the quaternion vector rotation block, bound to its top level.
`default_nettype none

module qvr_checker
   import qvr_pkg::*;
   (
      input wire logic    clock,
      input wire logic    reset,
      input wire logic    req_ready,
      input wire logic    rsp_valid,
      input wire logic    rsp_ready,
      input wire vec_type rot_x,
      input wire vec_type rot_y,
      input wire vec_type rot_z,
      input wire logic    clipped
   );

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
                                  && $stable(clipped))
      else $error("response payload changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A clipped response has at least one component at a saturation limit.
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |->
         rot_x == VEC_MAX || rot_x == VEC_MIN || rot_y == VEC_MAX || rot_y == VEC_MIN
         || rot_z == VEC_MAX || rot_z == VEC_MIN)
      else $error("clipped flag without a saturated component");

   // When the receiver takes responses, the pipeline always takes a request.
   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while the response side is ready");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rot_x     (rsp_chan.rot_x),
   .rot_y     (rsp_chan.rot_y),
   .rot_z     (rsp_chan.rot_z),
   .clipped   (rsp_chan.clipped)
);

`default_nettype wire

FILE: tb/tb_quaternion_vector_rotation.sv
// Testbench for the quaternion vector rotation block, checked against a built-in predictor.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotation
   import qvr_pkg::*;
   ();

   localparam int RANDOM_REQUESTS = 1150;
   localparam int CALM_TAIL       = 150;
   localparam int HOLD_CYCLES     = 80;
   localparam int HOLD_AFTER      = 400;
   localparam int DRAIN_CYCLES    = 24;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct {
      vec_type quat_w;
      vec_type quat_x;
      vec_type quat_y;
      vec_type quat_z;
      vec_type vec_x;
      vec_type vec_y;
      vec_type vec_z;
   } rotation_request_type;

   typedef struct {
      vec_type rot_x;
      vec_type rot_y;
      vec_type rot_z;
      logic    clipped;
   } rotated_vector_type;

   logic clock;
   logic reset;
   logic hold_off;

   qvr_req_if req_if ();
   qvr_rsp_if rsp_if ();

   rotation_request_type pending_requests[$];
   rotated_vector_type   expected_rotations[$];
   rotation_request_type offered;

   int requests_taken = 0;
   int mismatches     = 0;
   int cycle_count    = 0;
   int src_gap        = 0;
   int snk_gap        = 0;
   int src_idle_pct   = 10;
   int snk_idle_pct   = 10;

   quaternion_vector_rotation u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Hamilton product r = a * b, components ordered w, x, y, z.
   function automatic void hamilton_product(input longint a[4], input longint b[4],
                                            output longint r[4]);
      r[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
      r[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
      r[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
      r[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
   endfunction

   // Add half an LSB and shift right arithmetically, so ties go toward plus infinity.
   function automatic longint round_half_up(input longint s);
      return (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // Expected rotated vector for one request: q * (0,v) * conj(q) in fixed point.
   function automatic rotated_vector_type predict_rotation(input rotation_request_type rq);
      longint             q[4];
      longint             qc[4];
      longint             v[4];
      longint             p[4];
      longint             r[4];
      longint             c;
      vec_type            comp[3];
      rotated_vector_type res;
      q[0]  = longint'(rq.quat_w);
      q[1]  = longint'(rq.quat_x);
      q[2]  = longint'(rq.quat_y);
      q[3]  = longint'(rq.quat_z);
      qc[0] = q[0];
      qc[1] = -q[1];
      qc[2] = -q[2];
      qc[3] = -q[3];
      v[0]  = 0;
      v[1]  = longint'(rq.vec_x);
      v[2]  = longint'(rq.vec_y);
      v[3]  = longint'(rq.vec_z);
      hamilton_product(v, qc, p);
      // The intermediate product is kept at P_W bits, wrapping if it ever overflows.
      for (int i = 0; i < 4; i++) begin
         p[i] = longint'(p_type'(round_half_up(p[i])));
      end
      hamilton_product(q, p, r);
      res.clipped = 1'b0;
      for (int i = 1; i < 4; i++) begin
         c = round_half_up(r[i]);
         if (c > longint'(VEC_MAX)) begin
            c = longint'(VEC_MAX);
            res.clipped = 1'b1;
         end else if (c < longint'(VEC_MIN)) begin
            c = longint'(VEC_MIN);
            res.clipped = 1'b1;
         end
         comp[i-1] = vec_type'(c);
      end
      res.rot_x = comp[0];
      res.rot_y = comp[1];
      res.rot_z = comp[2];
      return res;
   endfunction

   // Compare one response with the oldest expected rotation.
   function automatic void check_rotation(input rotated_vector_type got);
      rotated_vector_type want;
      if (expected_rotations.size() == 0) begin
         $display("%0t: unexpected response x=%0d y=%0d z=%0d clipped=%0b", $time,
                  got.rot_x, got.rot_y, got.rot_z, got.clipped);
         mismatches++;
         return;
      end
      want = expected_rotations.pop_front();
      if (got.rot_x !== want.rot_x) begin
         $display("%0t: rot_x expected %0d actual %0d", $time, want.rot_x, got.rot_x);
         mismatches++;
      end
      if (got.rot_y !== want.rot_y) begin
         $display("%0t: rot_y expected %0d actual %0d", $time, want.rot_y, got.rot_y);
         mismatches++;
      end
      if (got.rot_z !== want.rot_z) begin
         $display("%0t: rot_z expected %0d actual %0d", $time, want.rot_z, got.rot_z);
         mismatches++;
      end
      if (got.clipped !== want.clipped) begin
         $display("%0t: clipped expected %0b actual %0b", $time, want.clipped, got.clipped);
         mismatches++;
      end
   endfunction

   function automatic void queue_request(input int w, input int x, input int y, input int z,
                                         input int vx, input int vy, input int vz);
      rotation_request_type rq;
      rq.quat_w = vec_type'(w);
      rq.quat_x = vec_type'(x);
      rq.quat_y = vec_type'(y);
      rq.quat_z = vec_type'(z);
      rq.vec_x  = vec_type'(vx);
      rq.vec_y  = vec_type'(vy);
      rq.vec_z  = vec_type'(vz);
      pending_requests.push_back(rq);
   endfunction

   // One random component: full range, roughly unit scale, or a corner value.
   function automatic int random_component(input int mode);
      int corner;
      if (mode <= 3) begin
         return int'(vec_type'($urandom_range(0, 65535)));
      end
      if (mode <= 7) begin
         return int'($urandom_range(0, 32768)) - 16384;
      end
      corner = $urandom_range(0, 7);
      case (corner)
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         5: return 16384;
         6: return -16384;
         default: return int'(vec_type'($urandom_range(0, 65535)));
      endcase
   endfunction

   function automatic int pick_idle_odds();
      int choice;
      choice = $urandom_range(0, 2);
      return (choice == 0) ? 0 : ((choice == 1) ? 10 : 35);
   endfunction

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit, in case the handshake hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Request driver: presents pending requests, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         src_gap      <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            expected_rotations.push_back(predict_rotation(offered));
            requests_taken <= requests_taken + 1;
         end
         if ($urandom_range(0, 63) == 0) begin
            src_idle_pct <= pick_idle_odds();
         end
         if (src_gap > 0) begin
            req_if.valid <= 1'b0;
            src_gap      <= src_gap - 1;
         end else if (pending_requests.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (!hold_off && pending_requests.size() > CALM_TAIL &&
                      $urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            src_gap      <= $urandom_range(0, 12);
         end else begin
            offered       <= pending_requests[0];
            req_if.quat_w <= pending_requests[0].quat_w;
            req_if.quat_x <= pending_requests[0].quat_x;
            req_if.quat_y <= pending_requests[0].quat_y;
            req_if.quat_z <= pending_requests[0].quat_z;
            req_if.vec_x  <= pending_requests[0].vec_x;
            req_if.vec_y  <= pending_requests[0].vec_y;
            req_if.vec_z  <= pending_requests[0].vec_z;
            req_if.valid  <= 1'b1;
            void'(pending_requests.pop_front());
         end
      end
   end

   // Response monitor: checks accepted responses and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         snk_gap      <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_rotation('{rsp_if.rot_x, rsp_if.rot_y, rsp_if.rot_z, rsp_if.clipped});
         end
         if ($urandom_range(0, 63) == 0) begin
            snk_idle_pct <= pick_idle_odds();
         end
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
         end else if (snk_gap > 0) begin
            rsp_if.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
         end else if (pending_requests.size() > CALM_TAIL &&
                      $urandom_range(0, 99) < snk_idle_pct) begin
            rsp_if.ready <= 1'b0;
            snk_gap      <= $urandom_range(0, 12);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off partway through, so the pipeline fills and stalls requests.
   initial begin
      hold_off = 1'b0;
      wait (requests_taken >= HOLD_AFTER);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Stimulus, reset and end of run.
   initial begin
      int mode;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.quat_w = '0;
      req_if.quat_x = '0;
      req_if.quat_y = '0;
      req_if.quat_z = '0;
      req_if.vec_x  = '0;
      req_if.vec_y  = '0;
      req_if.vec_z  = '0;
      rsp_if.ready  = 1'b0;

      // Identity, zero and negated identity quaternions.
      queue_request(16384, 0, 0, 0, 16384, -16384, 8192);
      queue_request(0, 0, 0, 0, 12345, -23456, 32767);
      queue_request(-16384, 0, 0, 0, -1, -1, -1);
      // Quarter turns about each axis, a half turn about x and a non-unit half turn about z.
      queue_request(11585, 0, 0, 11585, 16384, 0, 0);
      queue_request(11585, 11585, 0, 0, 0, 16384, 0);
      queue_request(11585, 0, 11585, 0, 0, 0, 16384);
      queue_request(0, 16384, 0, 0, 1000, 2000, -3000);
      queue_request(0, 0, 0, -32768, -32768, -32768, -32768);
      // Field extremes, non-unit quaternions that saturate the output, and an all-zero request.
      queue_request(32767, 32767, 32767, 32767, 32767, 32767, 32767);
      queue_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
      queue_request(-32768, 32767, -32768, 32767, 32767, -32768, 32767);
      queue_request(32767, 0, 0, 0, 32767, -32768, 100);
      queue_request(-32768, 0, 0, 0, 32767, -32768, 0);
      queue_request(0, 0, 0, 0, 0, 0, 0);
      // Exact halfway cases in the rounding of the intermediate product.
      queue_request(1, 0, 0, 0, 8192, -8192, 24576);
      queue_request(-1, 0, 0, 0, 8192, -8192, -24576);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         mode = $urandom_range(0, 9);
         queue_request(random_component(mode), random_component(mode),
                       random_component(mode), random_component(mode),
                       random_component(mode), random_component(mode),
                       random_component(mode));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: quaternion_vector_rotation.f
rtl/core/qvr_pkg.sv
rtl/core/qvr_if.sv
rtl/core/quaternion_vector_rotation.sv
rtl/core/qvr_checker.sv
tb/tb_quaternion_vector_rotation.sv
